// File: hw/rtl/gccs_pkg.sv
package gccs_pkg;

	localparam int unsigned HASH_BITS = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned GEAR_DEPTH = 256;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_BEGIN = 2'd1,
		REQ_DATA  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_CUT   = 2'd1,
		ST_LIMIT = 2'd2,
		ST_DONE  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_SIZE = 3'd0,
		CFG_CUT_MASK    = 3'd1,
		CFG_NORMAL_MASK = 3'd2,
		CFG_SCAN_BEGIN  = 3'd3,
		CFG_SCAN_END    = 3'd4
	} cfg_index_t;

	localparam logic [6:0]           WINDOW_SIZE_RST = 7'd32;
	localparam logic [HASH_BITS-1:0] CUT_MASK_RST    = 32'd8191;
	localparam logic [HASH_BITS-1:0] NORMAL_MASK_RST = 32'd0;
	localparam logic [31:0]          SCAN_BEGIN_RST  = 32'd64;
	localparam logic [31:0]          SCAN_END_RST    = 32'd65536;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  table_index;
		logic [31:0] table_word;
		logic [7:0]  data_byte;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  scan_status;
		logic [31:0] cut_position;
		logic [31:0] probe_count;
	} res_word_t;

endpackage

// File: hw/rtl/gear_cdc_cut_scan.sv
// Channel  Direction  Word type            Handshake
// req      in         gccs_pkg::req_word_t req_valid / req_stall
// res      out        gccs_pkg::res_word_t res_valid / res_stall
// cfg      in         cfg_index, cfg_data  cfg_we, no wait
// One word is accepted per cycle while req_stall is low; an accepted data word passes from the
// RAM reads and stage one into the output register. The rate is set by the hash update in stage
// one, which also picks the window RAM read address for the next word within the same cycle.
// Reset clears control state only; the gear table and the window RAM are not cleared.
// A held output register stops stage one while it holds a data word, and raises req_stall in the same cycle.
module gear_cdc_cut_scan #(
	parameter int unsigned MAX_WINDOW = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  gccs_pkg::req_word_t                    req_word,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output gccs_pkg::res_word_t                    res_word,
	input  logic                                   cfg_we,
	input  logic [gccs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gccs_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned WW = $clog2(MAX_WINDOW + 1);
	localparam int unsigned IW = AW + 2;
	localparam int unsigned GAW = $clog2(gccs_pkg::GEAR_DEPTH);
	localparam int unsigned HB = gccs_pkg::HASH_BITS;

	logic [6:0]    cfg_wsize_q;
	logic [HB-1:0] cfg_cut_mask_q;
	logic [HB-1:0] cfg_norm_mask_q;
	logic [31:0]   cfg_begin_q;
	logic [31:0]   cfg_end_q;

	logic [HB-1:0] hash_q;
	logic [31:0]   pos_q;
	logic [31:0]   probes_q;
	logic          fin_q;
	logic [AW-1:0] head_q;

	logic          s1_valid;
	logic          s1_begin;
	logic          fwd_s1;
	logic [HB-1:0] fwd_data_s1;

	logic          res_valid_q;
	gccs_pkg::res_word_t res_word_q;

	logic          req_accept;
	logic          req_is_load;
	logic          req_is_begin;
	logic          req_is_data;
	logic          s1_adv;
	logic          s1_commit;

	logic [WW-1:0] w_eff;
	logic [HB-1:0] gear_rdata;
	logic [HB-1:0] win_rdata;
	logic [HB-1:0] old_gear;
	logic          win_we;
	logic [AW-1:0] win_raddr;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_after;
	logic [IW-1:0] head_ext;
	logic [IW-1:0] w_ext;

	logic          prime;
	logic          over;
	logic          last;
	logic          hit;
	logic          push;
	gccs_pkg::status_t st;
	logic [31:0]   cut;
	logic [HB-1:0] hash_d;
	logic [31:0]   pos_d;
	logic [31:0]   probes_d;
	logic          fin_d;
	logic          begin_bad;

	always_comb begin
		if (cfg_wsize_q == 7'd0) begin
			w_eff = WW'(1);
		end else if (9'(cfg_wsize_q) > 9'(MAX_WINDOW)) begin
			w_eff = WW'(MAX_WINDOW);
		end else begin
			w_eff = WW'(cfg_wsize_q);
		end
	end

	assign req_is_load  = (req_word.req_type == gccs_pkg::REQ_LOAD);
	assign req_is_begin = (req_word.req_type == gccs_pkg::REQ_BEGIN);
	assign req_is_data  = (req_word.req_type == gccs_pkg::REQ_DATA);

	assign s1_adv     = !s1_valid || s1_begin || !res_valid_q || !res_stall;
	assign req_stall  = !s1_adv;
	assign req_accept = req_valid && !req_stall;
	assign s1_commit  = s1_valid && s1_adv;

	assign old_gear = fwd_s1 ? fwd_data_s1 : win_rdata;

	always_comb begin
		prime = (pos_q < cfg_begin_q);
		over  = (pos_q >= cfg_end_q);
		last  = ({1'b0, pos_q} + 33'd1) >= {1'b0, cfg_end_q};
		hit   = ((hash_q & cfg_cut_mask_q) == '0) &&
			((cfg_norm_mask_q == '0) || ((hash_q & cfg_norm_mask_q) == cfg_norm_mask_q));
	end

	always_comb begin
		st       = gccs_pkg::ST_RUN;
		cut      = '0;
		push     = 1'b0;
		hash_d   = hash_q;
		pos_d    = pos_q;
		probes_d = probes_q;
		fin_d    = fin_q;
		if (fin_q) begin
			st = gccs_pkg::ST_DONE;
		end else if (prime) begin
			hash_d = (hash_q << 1) + gear_rdata;
			push   = 1'b1;
			pos_d  = pos_q + 32'd1;
		end else if (over) begin
			st    = gccs_pkg::ST_LIMIT;
			fin_d = 1'b1;
		end else begin
			probes_d = probes_q + 32'd1;
			if (hit) begin
				st    = gccs_pkg::ST_CUT;
				cut   = pos_q;
				fin_d = 1'b1;
			end else begin
				hash_d = (hash_q << 1) + gear_rdata - old_gear;
				push   = 1'b1;
				pos_d  = pos_q + 32'd1;
				if (last) begin
					st    = gccs_pkg::ST_LIMIT;
					fin_d = 1'b1;
				end
			end
		end
	end

	assign begin_bad = (cfg_begin_q < 32'(w_eff)) || (cfg_begin_q >= cfg_end_q);

	// The next word's window read must see where this word leaves the ring head.
	assign head_inc = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
	assign win_we   = s1_commit && !s1_begin && push;

	always_comb begin
		if (s1_valid && s1_begin) begin
			head_after = '0;
		end else if (s1_valid && push) begin
			head_after = head_inc;
		end else begin
			head_after = head_q;
		end
		head_ext = IW'(head_after);
		w_ext    = IW'(w_eff);
		if (head_ext >= w_ext) begin
			win_raddr = AW'(head_ext - w_ext);
		end else begin
			win_raddr = AW'(head_ext + IW'(MAX_WINDOW) - w_ext);
		end
	end

	gccs_ram #(
		.WIDTH (HB),
		.DEPTH (gccs_pkg::GEAR_DEPTH)
	) u_gear_ram (
		.clk   (clk),
		.we    (req_accept && req_is_load),
		.waddr (GAW'(req_word.table_index)),
		.wdata (req_word.table_word),
		.re    (req_accept && req_is_data),
		.raddr (GAW'(req_word.data_byte)),
		.rdata (gear_rdata)
	);

	gccs_ram #(
		.WIDTH (HB),
		.DEPTH (MAX_WINDOW)
	) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (head_q),
		.wdata (gear_rdata),
		.re    (req_accept && req_is_data),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_wsize_q     <= gccs_pkg::WINDOW_SIZE_RST;
			cfg_cut_mask_q  <= gccs_pkg::CUT_MASK_RST;
			cfg_norm_mask_q <= gccs_pkg::NORMAL_MASK_RST;
			cfg_begin_q     <= gccs_pkg::SCAN_BEGIN_RST;
			cfg_end_q       <= gccs_pkg::SCAN_END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gccs_pkg::CFG_WINDOW_SIZE: cfg_wsize_q     <= cfg_data[6:0];
				gccs_pkg::CFG_CUT_MASK:    cfg_cut_mask_q  <= cfg_data;
				gccs_pkg::CFG_NORMAL_MASK: cfg_norm_mask_q <= cfg_data;
				gccs_pkg::CFG_SCAN_BEGIN:  cfg_begin_q     <= cfg_data;
				gccs_pkg::CFG_SCAN_END:    cfg_end_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_begin <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (s1_adv) begin
			s1_valid <= req_accept && (req_is_begin || req_is_data);
			s1_begin <= req_is_begin;
			fwd_s1   <= win_we && (head_q == win_raddr);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fwd_data_s1 <= gear_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q   <= '0;
			pos_q    <= '0;
			probes_q <= '0;
			fin_q    <= 1'b0;
			head_q   <= '0;
		end else if (s1_commit) begin
			if (s1_begin) begin
				hash_q   <= '0;
				pos_q    <= cfg_begin_q - 32'(w_eff);
				probes_q <= '0;
				fin_q    <= begin_bad;
				head_q   <= '0;
			end else begin
				hash_q   <= hash_d;
				pos_q    <= pos_d;
				probes_q <= probes_d;
				fin_q    <= fin_d;
				head_q   <= push ? head_inc : head_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_commit && !s1_begin) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_commit && !s1_begin) begin
			res_word_q.scan_status  <= st;
			res_word_q.cut_position <= cut;
			res_word_q.probe_count  <= probes_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		s1_commit && !s1_begin |-> !res_valid_q || !res_stall)
		else $error("stage one overwrote a held result word");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		s1_commit && !s1_begin && (st == gccs_pkg::ST_CUT || st == gccs_pkg::ST_LIMIT)
		|=> fin_q)
		else $error("scan not marked finished after a cut or limit");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_commit && !s1_begin && fin_q
		|=> $stable(hash_q) && $stable(pos_q) && $stable(probes_q))
		else $error("finished scan changed its state");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(MAX_WINDOW - 1))
		else $error("ring head left the window range");

endmodule

// File: hw/rtl/gccs_ram.sv
module gccs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/tb_top.sv
module tb_top;

	localparam int unsigned WIN_MAX       = 64;
	localparam int unsigned QUIET_LIMIT   = 5000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned PHASE_ITEMS   = 220;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            req_valid = 1'b0;
	logic                            req_stall;
	gccs_pkg::req_word_t             req_word  = '0;
	logic                            res_valid;
	logic                            res_stall = 1'b0;
	gccs_pkg::res_word_t             res_word;
	logic                            cfg_we    = 1'b0;
	logic [gccs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [gccs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	gear_cdc_cut_scan #(.MAX_WINDOW(WIN_MAX)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5;
		clk = 1'b1;
		#5;
		clk = 1'b0;
	end

	// Scan state mirrored from the block, with its copy of the registers.
	logic [31:0] gear_mem [gccs_pkg::GEAR_DEPTH];
	logic [31:0] ring_mem [WIN_MAX];
	int unsigned ring_ptr   = 0;
	logic [31:0] hash_q     = '0;
	logic [31:0] pos_q      = '0;
	logic [31:0] probes_q   = '0;
	logic        done_q     = 1'b0;
	logic [6:0]  win_reg    = gccs_pkg::WINDOW_SIZE_RST;
	logic [31:0] cutm_reg   = gccs_pkg::CUT_MASK_RST;
	logic [31:0] normm_reg  = gccs_pkg::NORMAL_MASK_RST;
	logic [31:0] begin_reg  = gccs_pkg::SCAN_BEGIN_RST;
	logic [31:0] end_reg    = gccs_pkg::SCAN_END_RST;

	gccs_pkg::res_word_t scan_report_q [$];
	gccs_pkg::res_word_t want_word;
	int unsigned err_count    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned src_idle_pct = 33;
	int unsigned snk_idle_pct = 72;
	int unsigned hold_len     = 0;
	int unsigned hold_left    = 0;

	function automatic int unsigned window_len(input logic [6:0] raw);
		if (raw == 7'd0) begin
			return 1;
		end
		if (raw > WIN_MAX) begin
			return WIN_MAX;
		end
		return {25'd0, raw};
	endfunction

	function automatic void push_window(input logic [31:0] g);
		ring_mem[ring_ptr] = g;
		ring_ptr = (ring_ptr + 1) % WIN_MAX;
	endfunction

	function automatic bit gear_scan_predict(input gccs_pkg::req_word_t w,
			output gccs_pkg::res_word_t r);
		int unsigned wn;
		int unsigned old_idx;
		logic [31:0] g;
		logic [31:0] h;
		logic [32:0] nxt;
		wn = window_len(win_reg);
		r = '0;
		case (w.req_type)
			gccs_pkg::REQ_LOAD: begin
				gear_mem[w.table_index] = w.table_word;
				return 1'b0;
			end
			gccs_pkg::REQ_BEGIN: begin
				hash_q = '0;
				probes_q = '0;
				ring_ptr = 0;
				done_q = (begin_reg < wn) || (begin_reg >= end_reg);
				pos_q = begin_reg - wn;
				return 1'b0;
			end
			gccs_pkg::REQ_DATA: ;
			default: return 1'b0;
		endcase
		g = gear_mem[w.data_byte];
		r.scan_status = gccs_pkg::ST_RUN;
		if (done_q) begin
			r.scan_status = gccs_pkg::ST_DONE;
		end else if (pos_q < begin_reg) begin
			hash_q = (hash_q << 1) + g;
			push_window(g);
			pos_q = pos_q + 1;
		end else if (pos_q >= end_reg) begin
			r.scan_status = gccs_pkg::ST_LIMIT;
			done_q = 1'b1;
		end else begin
			h = hash_q;
			probes_q = probes_q + 1;
			if ((h & cutm_reg) == 0 && (normm_reg == 0 || (h & normm_reg) == normm_reg)) begin
				r.scan_status = gccs_pkg::ST_CUT;
				r.cut_position = pos_q;
				done_q = 1'b1;
			end else begin
				old_idx = (ring_ptr + WIN_MAX - wn) % WIN_MAX;
				hash_q = (h << 1) + g - ring_mem[old_idx];
				push_window(g);
				nxt = {1'b0, pos_q} + 33'd1;
				pos_q = pos_q + 1;
				if (nxt >= {1'b0, end_reg}) begin
					r.scan_status = gccs_pkg::ST_LIMIT;
					done_q = 1'b1;
				end
			end
		end
		r.probe_count = probes_q;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch in %s: got %h expected %h", what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (res_valid && !res_stall) begin
			if (scan_report_q.size() == 0) begin
				report_mismatch("unexpected word", res_word.probe_count, '0);
			end else begin
				want_word = scan_report_q.pop_front();
				if (res_word.scan_status !== want_word.scan_status) begin
					report_mismatch("scan_status", {30'd0, res_word.scan_status},
						{30'd0, want_word.scan_status});
				end
				if (res_word.cut_position !== want_word.cut_position) begin
					report_mismatch("cut_position", res_word.cut_position,
						want_word.cut_position);
				end
				if (res_word.probe_count !== want_word.probe_count) begin
					report_mismatch("probe_count", res_word.probe_count,
						want_word.probe_count);
				end
			end
		end
	end

	// A requested hold-off keeps the result side stalled for a counted stretch.
	always @(posedge clk) begin
		if (hold_len != 0) begin
			hold_left = hold_len;
			hold_len = 0;
		end
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < snk_idle_pct);
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic gccs_pkg::req_word_t make_word(input gccs_pkg::req_type_t kind,
			input logic [7:0] idx, input logic [31:0] gword, input logic [7:0] dbyte);
		gccs_pkg::req_word_t w;
		w.req_type = kind;
		w.table_index = idx;
		w.table_word = gword;
		w.data_byte = dbyte;
		return w;
	endfunction

	function automatic logic [31:0] sparse_mask(input int unsigned bits);
		logic [31:0] m;
		m = '0;
		repeat (bits) m |= 32'h1 << $urandom_range(31);
		return m;
	endfunction

	task automatic send_word(input gccs_pkg::req_word_t w);
		gccs_pkg::res_word_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (gear_scan_predict(w, r)) begin
			scan_report_q.push_back(r);
		end
	endtask

	task automatic send_data(input logic [7:0] dbyte);
		send_word(make_word(gccs_pkg::REQ_DATA, 8'($urandom), $urandom, dbyte));
	endtask

	task automatic send_begin();
		send_word(make_word(gccs_pkg::REQ_BEGIN, 8'($urandom), $urandom, 8'($urandom)));
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (scan_report_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input gccs_pkg::cfg_index_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			gccs_pkg::CFG_WINDOW_SIZE: win_reg = val[6:0];
			gccs_pkg::CFG_CUT_MASK:    cutm_reg = val;
			gccs_pkg::CFG_NORMAL_MASK: normm_reg = val;
			gccs_pkg::CFG_SCAN_BEGIN:  begin_reg = val;
			gccs_pkg::CFG_SCAN_END:    end_reg = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [31:0] win, input logic [31:0] cutm,
			input logic [31:0] normm, input logic [31:0] sbeg, input logic [31:0] slim);
		wait_idle();
		write_reg(gccs_pkg::CFG_WINDOW_SIZE, win);
		write_reg(gccs_pkg::CFG_CUT_MASK, cutm);
		write_reg(gccs_pkg::CFG_NORMAL_MASK, normm);
		write_reg(gccs_pkg::CFG_SCAN_BEGIN, sbeg);
		write_reg(gccs_pkg::CFG_SCAN_END, slim);
		cfg_we <= 1'b0;
	endtask

	task automatic test_gear_load();
		logic [31:0] gword;
		for (int i = 0; i < gccs_pkg::GEAR_DEPTH; i++) begin
			gword = $urandom;
			if (i == 0) begin
				gword = '0;
			end else if (i == gccs_pkg::GEAR_DEPTH - 1) begin
				gword = '1;
			end
			send_word(make_word(gccs_pkg::REQ_LOAD, i[7:0], gword, 8'($urandom)));
		end
		wait_idle();
	endtask

	// Data arriving with no begin runs from the reset position, and a
	// position past the limit after priming ends the scan without a probe.
	task automatic test_no_begin();
		apply_settings(32'd4, 32'hFFFF_FFFF, 32'd0, 32'd4, 32'd3);
		repeat (6) send_data(8'($urandom));
		wait_idle();
	endtask

	// A zero window acts as one byte; an empty cut mask cuts on the first probe.
	task automatic test_cut_and_finish();
		apply_settings(32'd0, 32'd0, 32'd0, 32'd1, 32'd2);
		send_begin();
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'($urandom));
		wait_idle();
	endtask

	task automatic test_bad_range();
		apply_settings(32'd5, 32'd8191, 32'd0, 32'd10, 32'd10);
		send_begin();
		send_data(8'($urandom));
		send_word(make_word(gccs_pkg::REQ_NONE, 8'($urandom), $urandom, 8'($urandom)));
		apply_settings(32'd127, 32'd8191, 32'd0, 32'd63, 32'd100);
		send_begin();
		send_data(8'($urandom));
		wait_idle();
	endtask

	task automatic test_last_probe();
		apply_settings(32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFD, 32'hFFFF_FFFF);
		send_begin();
		repeat (4) send_data(8'($urandom));
		wait_idle();
	endtask

	task automatic test_normal_mask();
		apply_settings(32'd2, 32'd0, sparse_mask(2) | 32'h1, 32'd2, 32'd6);
		send_begin();
		repeat (6) send_data(8'($urandom));
		wait_idle();
	endtask

	task automatic test_backpressure();
		int unsigned saved_pct;
		saved_pct = src_idle_pct;
		src_idle_pct = 0;
		apply_settings(32'd3, 32'hFFFF_FFFF, 32'd0, 32'd3, 32'hFFFF_FFFF);
		send_begin();
		hold_len = HOLD_CYCLES;
		repeat (40) send_data(8'($urandom));
		wait_idle();
		src_idle_pct = saved_pct;
	endtask

	task automatic test_random_scans(input int unsigned budget);
		int unsigned sent;
		int unsigned weff;
		int unsigned nbytes;
		logic [31:0] win;
		logic [31:0] cutm;
		logic [31:0] normm;
		logic [31:0] sbeg;
		logic [31:0] slim;
		logic [32:0] sum;
		gccs_pkg::req_word_t noise;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(9))
				6: win = 32'd0;
				7: win = 32'd64;
				8: win = 32'd127;
				9: win = $urandom;
				default: win = $urandom_range(1, 8);
			endcase
			case ($urandom_range(9))
				6: cutm = 32'd0;
				7: cutm = 32'hFFFF_FFFF;
				8, 9: cutm = sparse_mask($urandom_range(5, 8));
				default: cutm = sparse_mask($urandom_range(0, 4));
			endcase
			case ($urandom_range(7))
				0: normm = sparse_mask($urandom_range(1, 2));
				1: normm = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
				default: normm = 32'd0;
			endcase
			// Sometimes keep the window, so that the running scan may go on without a new begin.
			if ($urandom_range(7) == 0) begin
				win = {25'd0, win_reg};
			end
			weff = window_len(win[6:0]);
			case ($urandom_range(7))
				5: sbeg = 32'hFFFF_FFFF - $urandom_range(0, 100);
				6: sbeg = $urandom_range(WIN_MAX, 32'hFFFF_0000);
				7: sbeg = weff - 1;
				default: sbeg = weff + $urandom_range(0, 4);
			endcase
			sum = {1'b0, sbeg} + $urandom_range(1, 48);
			slim = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			case ($urandom_range(15))
				0: slim = 32'hFFFF_FFFF;
				1: slim = sbeg - $urandom_range(0, 3);
				default: ;
			endcase
			if (win[6:0] == win_reg && $urandom_range(3) == 0) begin
				apply_settings(win, cutm, normm, begin_reg, slim);
			end else begin
				apply_settings(win, cutm, normm, sbeg, slim);
				send_begin();
				sent++;
			end
			nbytes = weff + $urandom_range(0, 52);
			repeat (nbytes) begin
				if ($urandom_range(99) < 4) begin
					noise = make_word(gccs_pkg::req_type_t'($urandom_range(3)),
						8'($urandom), $urandom, 8'($urandom));
					send_word(noise);
					if (noise.req_type != gccs_pkg::REQ_NONE) begin
						sent++;
					end
				end
				send_data(8'($urandom));
				sent++;
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_gear_load();
		test_no_begin();
		test_cut_and_finish();
		test_bad_range();
		test_last_probe();
		test_normal_mask();
		test_backpressure();
		test_random_scans(PHASE_ITEMS);
		src_idle_pct = 72;
		snk_idle_pct = 33;
		test_random_scans(PHASE_ITEMS);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_scans(PHASE_ITEMS);
		wait_idle();
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
